>>> hdl/rsac_pkg.sv
// ----------------------------------------------------------------------------
// rsac_pkg
// shared types, widths and helpers for the corner split block
// ----------------------------------------------------------------------------
package rsac_pkg;

  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int EDGE_BITS  = COORD_BITS + 1;
  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_BITS  = 4;
  localparam int NUM_CORNERS = 4;

  // input word layout, lowest field first
  localparam int IN_RAW    = 4 * COORD_BITS + 4 * SIZE_BITS;
  localparam int IN_BITS   = ((IN_RAW + 7) / 8) * 8;
  localparam int OFS_CX    = 0;
  localparam int OFS_CY    = OFS_CX + COORD_BITS;
  localparam int OFS_CW    = OFS_CY + COORD_BITS;
  localparam int OFS_CH    = OFS_CW + SIZE_BITS;
  localparam int OFS_AX    = OFS_CH + SIZE_BITS;
  localparam int OFS_AY    = OFS_AX + COORD_BITS;
  localparam int OFS_AW    = OFS_AY + COORD_BITS;
  localparam int OFS_AH    = OFS_AW + SIZE_BITS;

  // output word layout
  localparam int OUT_RAW   = 2 * COORD_BITS + 2 * SIZE_BITS;
  localparam int OUT_BITS  = ((OUT_RAW + 7) / 8) * 8;

  typedef logic signed [EDGE_BITS-1:0] edge_t;

  typedef struct packed {
    logic  v;
    edge_t x;
    edge_t y;
    edge_t r;
    edge_t b;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN,
    ST_SORT,
    ST_MARK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic gen;
    logic sort;
    logic mark;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic gen_last;
    logic sort_last;
    logic none_left;
  } status_t;

  // true when a orders after b; empty slots order after all others
  function automatic logic slot_gt(input slot_t a, input slot_t b);
    logic res;
    if (a.v != b.v)      res = b.v;
    else if (a.x != b.x) res = a.x > b.x;
    else if (a.y != b.y) res = a.y > b.y;
    else if (a.r != b.r) res = a.r > b.r;
    else                 res = a.b > b.b;
    return res;
  endfunction

endpackage

>>> hdl/rect_split_at_corners.sv
// ----------------------------------------------------------------------------
// rect_split_at_corners
// splits an area rectangle at the corners of a cutter rectangle
// ----------------------------------------------------------------------------
// sequence: load, a cut at each of four corners, 16 sort phases, one mark
//   step, then emit: the first piece is registered in the output stage, and
//   one slot shifts out per cycle while no word waits for out_tready; new
//   input is taken only after the slots are empty; fewer pieces end sooner
// reset: rst_n synchronous active low, clears sequencer, counters, keep flags and output valid
// ----------------------------------------------------------------------------
module rect_split_at_corners (
  input  logic                          clk,
  input  logic                          rst_n,
  // cut_x, cut_y, cut_w, cut_h, area_x, area_y, area_w, area_h, zero pad
  input  logic [rsac_pkg::IN_BITS-1:0]  in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // piece_x, piece_y, piece_w, piece_h, zero pad
  output logic [rsac_pkg::OUT_BITS-1:0] out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic                          out_tlast
);
  import rsac_pkg::*;

  cmd_t    cmd;
  status_t stat;

  // sequencer: idle, corner cuts, sort phases, duplicate mark, emit
  rsac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slots sorted by odd-even transposition, then shifted out past the
  // duplicates; the output register lets each word wait for the sink
  rsac_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> hdl/rsac_ctrl.sv
// ----------------------------------------------------------------------------
// rsac_ctrl
// sequencer: load, corner cuts, sort, duplicate marking, emit
// ----------------------------------------------------------------------------
module rsac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rsac_pkg::status_t stat,
  output rsac_pkg::cmd_t    cmd
);
  import rsac_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_GEN;
      ST_GEN:  if (stat.gen_last) state_nxt = ST_SORT;
      ST_SORT: if (stat.sort_last) state_nxt = ST_MARK;
      ST_MARK: state_nxt = ST_EMIT;
      ST_EMIT: if (stat.none_left) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_GEN:  cmd.gen  = 1'b1;
      ST_SORT: cmd.sort = 1'b1;
      ST_MARK: cmd.mark = 1'b1;
      ST_EMIT: cmd.emit = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

>>> hdl/rsac_dp.sv
// ----------------------------------------------------------------------------
// rsac_dp
// datapath: operand registers, piece slots, transposition sorter, output stage
// ----------------------------------------------------------------------------
module rsac_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rsac_pkg::cmd_t                 cmd,
  output rsac_pkg::status_t              stat,
  input  logic [rsac_pkg::IN_BITS-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rsac_pkg::OUT_BITS-1:0]  out_tdata,
  output logic                           out_tlast
);
  import rsac_pkg::*;

  edge_t ax_r, ay_r, rx_r, by_r;
  edge_t cx_r, cy_r, cr_r, cb_r;
  logic [1:0]           corner_r;
  logic [SLOT_BITS-1:0] phase_r;
  slot_t                slot_r [NUM_SLOTS];
  slot_t                slot_nxt [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] keep_r, keep_nxt;
  logic                 out_valid_r;
  logic [OUT_BITS-1:0]  out_data_r;
  logic                 out_last_r;

  edge_t px, py;
  logic  hit, step;

  always_comb begin
    px = corner_r[0] ? cr_r : cx_r;
    py = corner_r[1] ? cb_r : cy_r;
  end

  assign hit = (px >= ax_r) && (px < rx_r) && (py >= ay_r) && (py < by_r);

  assign step = !keep_r[0] || !out_valid_r || out_tready;

  // sorter, dedup mark and emit shift
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) slot_nxt[i] = slot_r[i];
    keep_nxt = keep_r;
    if (cmd.sort) begin
      for (int i = 0; i < NUM_SLOTS - 1; i++) begin
        if ((i % 2) == int'(phase_r[0]) && slot_gt(slot_r[i], slot_r[i+1])) begin
          slot_nxt[i]   = slot_r[i+1];
          slot_nxt[i+1] = slot_r[i];
        end
      end
    end
    if (cmd.mark) begin
      keep_nxt[0] = slot_r[0].v;
      for (int i = 1; i < NUM_SLOTS; i++) begin
        keep_nxt[i] = slot_r[i].v && !(slot_r[i-1].v && slot_r[i] == slot_r[i-1]);
      end
    end
    if (cmd.emit && step) begin
      for (int i = 0; i < NUM_SLOTS - 1; i++) slot_nxt[i] = slot_r[i+1];
      keep_nxt = {1'b0, keep_r[NUM_SLOTS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r <= $signed({in_tdata[OFS_CX+COORD_BITS-1], in_tdata[OFS_CX +: COORD_BITS]});
      cy_r <= $signed({in_tdata[OFS_CY+COORD_BITS-1], in_tdata[OFS_CY +: COORD_BITS]});
      cr_r <= $signed({in_tdata[OFS_CX+COORD_BITS-1], in_tdata[OFS_CX +: COORD_BITS]})
            + $signed({2'b00, in_tdata[OFS_CW +: SIZE_BITS]});
      cb_r <= $signed({in_tdata[OFS_CY+COORD_BITS-1], in_tdata[OFS_CY +: COORD_BITS]})
            + $signed({2'b00, in_tdata[OFS_CH +: SIZE_BITS]});
      ax_r <= $signed({in_tdata[OFS_AX+COORD_BITS-1], in_tdata[OFS_AX +: COORD_BITS]});
      ay_r <= $signed({in_tdata[OFS_AY+COORD_BITS-1], in_tdata[OFS_AY +: COORD_BITS]});
      rx_r <= $signed({in_tdata[OFS_AX+COORD_BITS-1], in_tdata[OFS_AX +: COORD_BITS]})
            + $signed({2'b00, in_tdata[OFS_AW +: SIZE_BITS]});
      by_r <= $signed({in_tdata[OFS_AY+COORD_BITS-1], in_tdata[OFS_AY +: COORD_BITS]})
            + $signed({2'b00, in_tdata[OFS_AH +: SIZE_BITS]});
    end
  end

  // slots: four quadrants per corner, zero-area ones and those of a missed corner left empty
  always_ff @(posedge clk) begin
    if (cmd.gen) begin
      slot_r[{corner_r, 2'd0}] <= '{hit && px != ax_r && py != ay_r, ax_r, ay_r, px, py};
      slot_r[{corner_r, 2'd1}] <= '{hit && py != ay_r, px, ay_r, rx_r, py};
      slot_r[{corner_r, 2'd2}] <= '{hit && px != ax_r, ax_r, py, px, by_r};
      slot_r[{corner_r, 2'd3}] <= '{hit, px, py, rx_r, by_r};
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) slot_r[i] <= slot_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r    <= '0;
      phase_r     <= '0;
      keep_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.gen)  corner_r <= corner_r + 2'd1;
      if (cmd.sort) phase_r  <= phase_r + 1'b1;
      keep_r <= keep_nxt;
      if (cmd.emit && step && keep_r[0]) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && step && keep_r[0]) begin
      out_data_r <= OUT_BITS'({(slot_r[0].b - slot_r[0].y) & EDGE_BITS'((1 << SIZE_BITS) - 1),
                               SIZE_BITS'(slot_r[0].r - slot_r[0].x),
                               slot_r[0].y[COORD_BITS-1:0],
                               slot_r[0].x[COORD_BITS-1:0]});
      out_last_r <= ~|keep_r[NUM_SLOTS-1:1];
    end
  end

  assign stat.gen_last  = corner_r == 2'(NUM_CORNERS - 1);
  assign stat.sort_last = phase_r == SLOT_BITS'(NUM_SLOTS - 1);
  assign stat.none_left = ~|keep_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
